// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk_i outside reset.
`define GHD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define GHD_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== src/ghd_pkg.sv =====
// ----------------------------------------------------------------------------
// ghd_pkg
// Types and constants shared by the home distance core and its serial unit.
// ----------------------------------------------------------------------------
package ghd_pkg;

  localparam int unsigned EarthW = 18;
  localparam int unsigned EastW  = 17;
  localparam int unsigned HLatW  = 27;
  localparam int unsigned HLonW  = 28;
  localparam int unsigned DistW  = 16;

  localparam logic [EarthW-1:0] EARTH_RESET = 18'd111194;

  localparam logic [31:0] K_MICRO   = 32'd1000000;
  localparam logic [31:0] K_1E4     = 32'd10000;
  localparam logic [31:0] K_COS2    = 32'd123370;
  localparam logic [31:0] K_81      = 32'd81;
  localparam logic [31:0] K_25      = 32'd25;
  localparam logic [31:0] K_12500   = 32'd12500;
  localparam logic [31:0] K_139     = 32'd139;
  localparam logic [31:0] K_1E7     = 32'd10000000;
  localparam logic [31:0] K_100     = 32'd100;
  localparam logic [31:0] K_5       = 32'd5;
  localparam logic [31:0] K_3       = 32'd3;

  typedef enum logic [0:0] {
    OP_MEASURE  = 1'b0,
    OP_SET_HOME = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    ALU_MUL,
    ALU_DIV,
    ALU_SQRT
  } alu_op_e;

  typedef struct packed {
    logic        start;
    alu_op_e     op;
    logic [31:0] a;
    logic [31:0] b;
  } alu_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] res;
    logic [31:0] rem;
  } alu_rsp_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_LAT_DIV100, ST_LAT_MULQ, ST_LAT_MULR, ST_LAT_MUL5, ST_LAT_DIV3,
    ST_LON_DIV100, ST_LON_MULQ, ST_LON_MULR, ST_LON_MUL5, ST_LON_DIV3,
    ST_H_DEG, ST_H_SQ, ST_H_A2, ST_H_A4, ST_H_K, ST_H_D81, ST_H_D25, ST_H_P, ST_H_E,
    ST_M_NM, ST_M_ND, ST_M_NS, ST_M_EM, ST_M_ED, ST_M_ES, ST_M_AS, ST_M_RT,
    ST_FINISH
  } step_e;

endpackage

// ===== src/ghd_alu.sv =====
// ----------------------------------------------------------------------------
// ghd_alu
// Shared serial unit: shift-add multiply (1 bit/cycle), restoring divide
// (1 bit/cycle) and integer square root (2 bits/cycle). 32-bit wrapping.
// ----------------------------------------------------------------------------
module ghd_alu (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ghd_pkg::alu_req_t req_i,
  output ghd_pkg::alu_rsp_t rsp_o
);
  import ghd_pkg::*;

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  alu_op_e     op_q, op_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [32:0] p_q, p_d;
  logic [31:0] x_q, x_d;
  logic [31:0] y_q, y_d;

  logic [32:0] r2;
  logic [18:0] rs;
  logic [18:0] rt;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    op_d   = op_q;
    cnt_d  = cnt_q;
    p_d    = p_q;
    x_d    = x_q;
    y_d    = y_q;
    r2     = {p_q[31:0], y_q[31]};
    rs     = {p_q[16:0], y_q[30+:2]};
    rt     = {1'b0, x_q[15:0], 2'b01};
    if (req_i.start) begin
      busy_d = 1'b1;
      op_d   = req_i.op;
      p_d    = '0;
      if (req_i.op == ALU_SQRT) begin
        cnt_d = 5'd15;
        x_d   = '0;
        y_d   = req_i.a;
      end else if (req_i.op == ALU_DIV) begin
        // Shift the dividend out of y, hold the divisor in x.
        cnt_d = 5'd31;
        x_d   = req_i.b;
        y_d   = req_i.a;
      end else begin
        cnt_d = 5'd31;
        x_d   = req_i.a;
        y_d   = req_i.b;
      end
    end else if (busy_q) begin
      case (op_q)
        ALU_MUL: begin
          p_d = {1'b0, p_q[31:0] + (y_q[0] ? x_q : 32'd0)};
          x_d = {x_q[30:0], 1'b0};
          y_d = {1'b0, y_q[31:1]};
        end
        ALU_DIV: begin
          if (r2 >= {1'b0, x_q}) begin
            p_d = r2 - {1'b0, x_q};
            y_d = {y_q[30:0], 1'b1};
          end else begin
            p_d = r2;
            y_d = {y_q[30:0], 1'b0};
          end
        end
        ALU_SQRT: begin
          if (rs >= rt) begin
            p_d = {14'd0, rs - rt};
            x_d = {16'd0, x_q[14:0], 1'b1};
          end else begin
            p_d = {14'd0, rs};
            x_d = {16'd0, x_q[14:0], 1'b0};
          end
          y_d = {y_q[29:0], 2'b00};
        end
        default: begin
          p_d = p_q;
        end
      endcase
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q   <= ALU_MUL;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      op_q   <= op_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
    x_q <= x_d;
    y_q <= y_d;
  end

  always_comb begin
    rsp_o.done = done_q;
    rsp_o.rem  = p_q[31:0];
    case (op_q)
      ALU_MUL:  rsp_o.res = p_q[31:0];
      ALU_DIV:  rsp_o.res = y_q;
      ALU_SQRT: rsp_o.res = {16'd0, x_q[15:0]};
      default:  rsp_o.res = p_q[31:0];
    endcase
  end

endmodule

// ===== src/gps_home_distance_core.sv =====
// ----------------------------------------------------------------------------
// gps_home_distance_core
// Distance of a GPS fix from a stored home position, with peak tracking.
// ----------------------------------------------------------------------------
// Usage:
//  - Input stream s_axis: one transaction per fix. tuser selects the operation
//    (measure or set home) and which altitude to use; tdata holds the
//    degree-minute coordinates and both altitudes.
//  - Output stream m_axis: one transaction per fix with the distance, the
//    peak distance so far and the east-west meters per degree at home.
//  - APB port: register 0 holds the meters per degree of latitude.
//  - Every step runs on one shared serial unit: an operation is issued, steps
//    through its bits and is written back. A measurement issues 17 operations
//    plus the root before it loads its result; a set-home issues 19 operations.
//    One fix is in work at a time; s_axis_tready is high only while the
//    sequencer is idle, so a new fix is taken only after the last one is done.
//  - The result sits in an output register, so the next fix is taken while
//    the previous result waits. If the receiver stalls, the sequencer holds
//    its finished result until the output register frees up.
//  - Reset clears home, east scale and peak to zero and loads the register
//    with its default; no clearing pass is needed.
// ----------------------------------------------------------------------------
module gps_home_distance_core #(
  parameter logic [ghd_pkg::EarthW-1:0] EarthReset = ghd_pkg::EARTH_RESET
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // tdata: lat_whole[13:0], lat_frac[27:14], lon_whole[42:28], lon_frac[56:43],
  //        baro_alt[72:57], gps_alt[88:73], zero fill [95:89]
  input  logic [95:0] s_axis_tdata,
  // tuser: opcode[0], baro_valid[1]
  input  logic [1:0]  s_axis_tuser,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: distance[15:0], max_distance[31:16], east_scale[48:32], zero [55:49]
  output logic [55:0] m_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ghd_pkg::*;

  // Configuration
  logic [EarthW-1:0] earth_q;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & (paddr == 3'd0);
  assign prdata = (paddr == 3'd0) ? {14'd0, earth_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      earth_q <= EarthReset;
    end else if (cfg_wr) begin
      earth_q <= pwdata[EarthW-1:0];
    end
  end

  // Captured fix
  opcode_e      op_q;
  logic         baro_valid_q;
  logic [13:0]  lat_whole_q, lat_frac_q, lon_frac_q;
  logic [14:0]  lon_whole_q;
  logic [15:0]  baro_alt_q, gps_alt_q;

  // Working and state registers
  step_e             step_q, step_d;
  logic              issued_q;
  logic [31:0]       x_q, y_q, lat_q, lon_q, sum_q;
  logic [HLatW-1:0]  home_lat_q;
  logic [HLonW-1:0]  home_lon_q;
  logic [EastW-1:0]  east_q;
  logic [DistW-1:0]  dist_q, peak_q, peak_d;
  logic              out_valid_q;
  logic [55:0]       out_data_q;

  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  ghd_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .rsp_o  (alu_rsp)
  );

  logic        in_acc;
  logic        out_free;
  logic [31:0] diff_lat, diff_lon, home_lat_ext, home_lon_ext;
  logic [15:0] alt_raw;
  logic [16:0] alt_abs;
  logic [31:0] conv_sum;

  assign in_acc       = s_axis_tvalid & s_axis_tready;
  assign out_free     = ~out_valid_q | m_axis_tready;
  assign home_lat_ext = {5'd0, home_lat_q};
  assign home_lon_ext = {4'd0, home_lon_q};
  assign diff_lat     = (lat_q > home_lat_ext) ? lat_q - home_lat_ext : home_lat_ext - lat_q;
  assign diff_lon     = (lon_q > home_lon_ext) ? lon_q - home_lon_ext : home_lon_ext - lon_q;
  assign alt_raw      = baro_valid_q ? baro_alt_q : gps_alt_q;
  assign alt_abs      = alt_raw[15] ? 17'h10000 - {1'b0, alt_raw} : {1'b0, alt_raw};
  assign conv_sum     = x_q + alu_rsp.res;

  // Next state
  always_comb begin
    step_d = step_q;
    case (step_q)
      ST_IDLE:   if (s_axis_tvalid) step_d = ST_LAT_DIV100;
      ST_FINISH: if (out_free) step_d = ST_IDLE;
      default: begin
        if (alu_rsp.done) begin
          case (step_q)
            ST_LON_DIV3: step_d = (op_q == OP_SET_HOME) ? ST_H_DEG : ST_M_NM;
            ST_H_E:      step_d = ST_FINISH;
            ST_M_RT:     step_d = ST_FINISH;
            default:     step_d = step_e'(step_q + 5'd1);
          endcase
        end
      end
    endcase
  end

  // Outputs: handshake and operation issue
  always_comb begin
    s_axis_tready = (step_q == ST_IDLE);
    alu_req.start = ~issued_q && (step_q != ST_IDLE) && (step_q != ST_FINISH);
    alu_req.op    = ALU_MUL;
    alu_req.a     = 32'd0;
    alu_req.b     = 32'd0;
    case (step_q)
      ST_LAT_DIV100: begin alu_req.op = ALU_DIV; alu_req.a = {18'd0, lat_whole_q}; alu_req.b = K_100; end
      ST_LAT_MULQ:   begin alu_req.a = x_q; alu_req.b = K_MICRO; end
      ST_LAT_MULR:   begin alu_req.a = y_q; alu_req.b = K_1E4; end
      ST_LAT_MUL5:   begin alu_req.a = y_q + {18'd0, lat_frac_q}; alu_req.b = K_5; end
      ST_LAT_DIV3:   begin alu_req.op = ALU_DIV; alu_req.a = y_q; alu_req.b = K_3; end
      ST_LON_DIV100: begin alu_req.op = ALU_DIV; alu_req.a = {17'd0, lon_whole_q}; alu_req.b = K_100; end
      ST_LON_MULQ:   begin alu_req.a = x_q; alu_req.b = K_MICRO; end
      ST_LON_MULR:   begin alu_req.a = y_q; alu_req.b = K_1E4; end
      ST_LON_MUL5:   begin alu_req.a = y_q + {18'd0, lon_frac_q}; alu_req.b = K_5; end
      ST_LON_DIV3:   begin alu_req.op = ALU_DIV; alu_req.a = y_q; alu_req.b = K_3; end
      ST_H_DEG:      begin alu_req.op = ALU_DIV; alu_req.a = home_lat_ext; alu_req.b = K_1E4; end
      ST_H_SQ:       begin alu_req.a = x_q; alu_req.b = x_q; end
      ST_H_A2:       begin alu_req.op = ALU_DIV; alu_req.a = x_q; alu_req.b = K_1E4; end
      ST_H_A4:       begin alu_req.a = x_q; alu_req.b = x_q; end
      ST_H_K:        begin alu_req.a = x_q; alu_req.b = K_COS2; end
      ST_H_D81:      begin alu_req.op = ALU_DIV; alu_req.a = x_q; alu_req.b = K_81; end
      ST_H_D25:      begin alu_req.op = ALU_DIV; alu_req.a = y_q; alu_req.b = K_25; end
      ST_H_P:        begin alu_req.op = ALU_DIV; alu_req.a = K_1E7 - x_q + y_q; alu_req.b = K_12500; end
      ST_H_E:        begin alu_req.a = x_q; alu_req.b = K_139; end
      ST_M_NM:       begin alu_req.a = {14'd0, earth_q}; alu_req.b = diff_lat; end
      ST_M_ND:       begin alu_req.op = ALU_DIV; alu_req.a = x_q; alu_req.b = K_MICRO; end
      ST_M_NS:       begin alu_req.a = x_q; alu_req.b = x_q; end
      ST_M_EM:       begin alu_req.a = {15'd0, east_q}; alu_req.b = diff_lon; end
      ST_M_ED:       begin alu_req.op = ALU_DIV; alu_req.a = x_q; alu_req.b = K_MICRO; end
      ST_M_ES:       begin alu_req.a = x_q; alu_req.b = x_q; end
      ST_M_AS:       begin alu_req.a = {15'd0, alt_abs}; alu_req.b = {15'd0, alt_abs}; end
      ST_M_RT:       begin alu_req.op = ALU_SQRT; alu_req.a = sum_q; end
      default:       begin alu_req.op = ALU_MUL; end
    endcase
  end

  assign peak_d = (dist_q > peak_q) ? dist_q : peak_q;

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= ST_IDLE;
      issued_q    <= 1'b0;
      out_valid_q <= 1'b0;
      home_lat_q  <= '0;
      home_lon_q  <= '0;
      east_q      <= '0;
      peak_q      <= '0;
    end else begin
      step_q <= step_d;
      if (alu_rsp.done) begin
        issued_q <= 1'b0;
      end else if (alu_req.start) begin
        issued_q <= 1'b1;
      end
      if (step_q == ST_FINISH && out_free) begin
        out_valid_q <= 1'b1;
        peak_q      <= peak_d;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (alu_rsp.done && step_q == ST_LON_DIV3 && op_q == OP_SET_HOME) begin
        home_lat_q <= lat_q[HLatW-1:0];
        home_lon_q <= conv_sum[HLonW-1:0];
      end
      if (alu_rsp.done && step_q == ST_H_E) begin
        east_q <= alu_rsp.res[EastW-1:0];
      end
    end
  end

  // Payload registers: capture the fix and write back each operation
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q         <= opcode_e'(s_axis_tuser[0]);
      baro_valid_q <= s_axis_tuser[1];
      lat_whole_q  <= s_axis_tdata[13:0];
      lat_frac_q   <= s_axis_tdata[27:14];
      lon_whole_q  <= s_axis_tdata[42:28];
      lon_frac_q   <= s_axis_tdata[56:43];
      baro_alt_q   <= s_axis_tdata[72:57];
      gps_alt_q    <= s_axis_tdata[88:73];
      dist_q       <= '0;
    end
    if (step_q == ST_FINISH && out_free) begin
      out_data_q <= {7'd0, east_q, peak_d, dist_q};
    end
    if (alu_rsp.done) begin
      case (step_q)
        ST_LAT_DIV100, ST_LON_DIV100: begin
          x_q <= alu_rsp.res;
          y_q <= alu_rsp.rem;
        end
        ST_LAT_MULR, ST_LAT_MUL5, ST_LON_MULR, ST_LON_MUL5,
        ST_H_A4, ST_H_D25:            y_q   <= alu_rsp.res;
        ST_LAT_DIV3:                  lat_q <= conv_sum;
        ST_LON_DIV3:                  lon_q <= conv_sum;
        ST_M_NS:                      sum_q <= alu_rsp.res;
        ST_M_ES, ST_M_AS:             sum_q <= sum_q + alu_rsp.res;
        ST_M_RT:                      dist_q <= alu_rsp.res[DistW-1:0];
        default:                      x_q   <= alu_rsp.res;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  `include "assert_macros.svh"

  // Peak distance never drops.
  `GHD_ASSERT(a_peak_monotonic, 1'b1 |=> peak_q >= $past(peak_q), "peak distance decreased")
  // A result from the serial unit only comes back for an issued operation.
  `GHD_ASSERT(a_done_issued, alu_rsp.done |-> issued_q, "unit finished without issue")
  // A new result appears only out of the finishing step.
  `GHD_ASSERT(a_out_from_finish, $rose(out_valid_q) |-> $past(step_q == ST_FINISH), "result loaded outside finish step")
  // No operation is issued while idle.
  `GHD_NEVER(a_no_issue_idle, alu_req.start && step_q == ST_IDLE, "issue while idle")

endmodule
